[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: request codes, character
// codes, reset attribute and stream field widths.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // special character codes
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] CODE_BLANK     = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // field widths
    localparam int REQ_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int RROW_W   = 5;
    localparam int RCOL_W   = 7;
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;
    localparam int ATTR_W   = 8;

    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    typedef logic [CELL_W-1:0]   cell_t;
    typedef logic [CURSOR_W-1:0] cursor_t;

endpackage

[src/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port and
// registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[src/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// Text console engine over a ROWS x COLUMNS grid of 16-bit character cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream carries requests: s_tuser = request kind (put, clear, read),
//   s_tdata = character and read coordinates. m_* stream returns one beat per
//   request: cell value, linear cursor position, scrolled flag. cfg_* writes
//   the attribute byte; write it only while the block is idle.
// Request flow (a new request is taken only once the last one is done):
//   put character, backspace, newline without scroll, ignored kind: emit
//   read inside the grid: RAM read state, then emit; outside it: emit
//   put that scrolls: sweep state (one RAM write per cycle blanks the new
//   bottom row; scrolling itself only moves the top-row pointer), then emit
//   clear: sweep state (one RAM write per cell), then emit
//   The sweeps are paced by the single write port of the cell RAM.
// Reset: cursor, top row and attribute go to zero / 0x0F, then a sweep blanks
//   every grid cell of the RAM; s_tready stays low during it.
// Stall: results sit in an output register; one more request is accepted
//   and worked while a beat waits, then the block holds until it drains.
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
    input  logic [tcw_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] req_type
    input  logic [tcw_pkg::S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [15:0] cell_value, [26:16] cursor_pos, [27] scrolled, [31:28] zero
    output logic [tcw_pkg::M_TDATA_W-1:0] m_tdata,
    // attribute register write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (1 << CW);

    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_SWEEP = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // state
    logic [1:0]                          state_reg, state_next;
    logic [RW-1:0]                       cur_row_reg, cur_row_next;
    logic [CW-1:0]                       cur_col_reg, cur_col_next;
    logic [RW-1:0]                       top_reg, top_next;
    logic [tcw_pkg::ATTR_W-1:0]          attr_reg, attr_next;
    logic                                sweep_all_reg, sweep_all_next;
    logic                                sweep_emit_reg, sweep_emit_next;
    tcw_pkg::cell_t                      sweep_cell_reg, sweep_cell_next;
    logic [RW-1:0]                       sw_row_reg, sw_row_next;
    logic [CW-1:0]                       sw_col_reg, sw_col_next;
    tcw_pkg::cell_t                      pend_cell_reg, pend_cell_next;
    logic                                pend_scr_reg, pend_scr_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [tcw_pkg::M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    // request fields
    logic [tcw_pkg::REQ_W-1:0]  s_req;
    logic [tcw_pkg::CHAR_W-1:0] s_char;
    logic [tcw_pkg::RROW_W-1:0] s_rrow;
    logic [tcw_pkg::RCOL_W-1:0] s_rcol;
    logic                       s_fire;

    // RAM port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    tcw_pkg::cell_t        mem_wdata;
    logic [AW-1:0]         mem_raddr;
    tcw_pkg::cell_t        mem_rdata;

    logic [RW-1:0]         cur_prow;
    logic [RW-1:0]         rd_prow;
    logic [CW-1:0]         rd_col;
    logic                  rd_in_range;
    logic [RW-1:0]         top_inc;
    tcw_pkg::cursor_t      cursor_pos;
    tcw_pkg::cell_t        blank_cell;
    logic                  do_line;

    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] top,
                                               input logic [RW-1:0] row);
        logic [RW:0] sum;
        sum = {1'b0, top} + {1'b0, row};
        if (sum >= (RW+1)'(ROWS)) begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    assign s_req  = s_tuser[1:0];
    assign s_char = s_tdata[7:0];
    assign s_rrow = s_tdata[12:8];
    assign s_rcol = s_tdata[19:13];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign cur_prow    = phys_row(top_reg, cur_row_reg);
    assign rd_in_range = (32'(s_rrow) < 32'(ROWS)) && (32'(s_rcol) < 32'(COLUMNS));
    assign rd_prow     = phys_row(top_reg, RW'(32'(s_rrow)));
    assign rd_col      = CW'(32'(s_rcol));
    assign mem_raddr   = {rd_prow, rd_col};
    assign top_inc     = (top_reg == ROW_LAST) ? '0 : top_reg + 1'b1;
    assign blank_cell  = {attr_reg, tcw_pkg::CODE_BLANK};

    // row * COLUMNS + col, kept to the 11-bit field
    assign cursor_pos = tcw_pkg::CURSOR_W'(32'(cur_row_reg) * 32'(COLUMNS)
                                           + 32'(cur_col_reg));

    always_comb begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        top_next        = top_reg;
        attr_next       = attr_reg;
        sweep_all_next  = sweep_all_reg;
        sweep_emit_next = sweep_emit_reg;
        sweep_cell_next = sweep_cell_reg;
        sw_row_next     = sw_row_reg;
        sw_col_next     = sw_col_reg;
        pend_cell_next  = pend_cell_reg;
        pend_scr_next   = pend_scr_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        mem_we          = 1'b0;
        mem_waddr       = {sw_row_reg, sw_col_reg};
        mem_wdata       = sweep_cell_reg;
        do_line         = 1'b0;

        if (cfg_valid) begin
            attr_next = cfg_data;
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    pend_cell_next = '0;
                    pend_scr_next  = 1'b0;
                    state_next     = ST_EMIT;
                    unique case (s_req)
                        tcw_pkg::REQ_PUT: begin
                            if (s_char == tcw_pkg::CODE_NEWLINE) begin
                                do_line = 1'b1;
                            end else if (s_char == tcw_pkg::CODE_BACKSPACE) begin
                                if (cur_col_reg != '0) begin
                                    cur_col_next = cur_col_reg - 1'b1;
                                    mem_we       = 1'b1;
                                    mem_waddr    = {cur_prow, cur_col_reg - 1'b1};
                                    mem_wdata    = blank_cell;
                                end
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = {cur_prow, cur_col_reg};
                                mem_wdata = {attr_reg, s_char};
                                if (cur_col_reg == COL_LAST) begin
                                    do_line = 1'b1;
                                end else begin
                                    cur_col_next = cur_col_reg + 1'b1;
                                end
                            end
                            if (do_line) begin
                                cur_col_next = '0;
                                if (cur_row_reg != ROW_LAST) begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end else begin
                                    // old top physical row becomes the new bottom
                                    top_next        = top_inc;
                                    pend_scr_next   = 1'b1;
                                    sw_row_next     = top_reg;
                                    sw_col_next     = '0;
                                    sweep_all_next  = 1'b0;
                                    sweep_emit_next = 1'b1;
                                    sweep_cell_next = blank_cell;
                                    state_next      = ST_SWEEP;
                                end
                            end
                        end
                        tcw_pkg::REQ_CLEAR: begin
                            cur_row_next    = '0;
                            cur_col_next    = '0;
                            top_next        = '0;
                            sw_row_next     = '0;
                            sw_col_next     = '0;
                            sweep_all_next  = 1'b1;
                            sweep_emit_next = 1'b1;
                            sweep_cell_next = blank_cell;
                            state_next      = ST_SWEEP;
                        end
                        tcw_pkg::REQ_READ: begin
                            if (rd_in_range) begin
                                state_next = ST_READ;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_READ: begin
                pend_cell_next = mem_rdata;
                state_next     = ST_EMIT;
            end
            ST_SWEEP: begin
                mem_we = 1'b1;
                if (sw_col_reg == COL_LAST) begin
                    sw_col_next = '0;
                    if (!sweep_all_reg || sw_row_reg == ROW_LAST) begin
                        state_next = sweep_emit_reg ? ST_EMIT : ST_IDLE;
                    end else begin
                        sw_row_next = sw_row_reg + 1'b1;
                    end
                end else begin
                    sw_col_next = sw_col_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, pend_scr_reg, cursor_pos, pend_cell_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_SWEEP;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            attr_reg       <= tcw_pkg::ATTR_RESET;
            sweep_all_reg  <= 1'b1;
            sweep_emit_reg <= 1'b0;
            sweep_cell_reg <= {tcw_pkg::ATTR_RESET, tcw_pkg::CODE_BLANK};
            sw_row_reg     <= '0;
            sw_col_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            top_reg        <= top_next;
            attr_reg       <= attr_next;
            sweep_all_reg  <= sweep_all_next;
            sweep_emit_reg <= sweep_emit_next;
            sweep_cell_reg <= sweep_cell_next;
            sw_row_reg     <= sw_row_next;
            sw_col_reg     <= sw_col_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_cell_reg <= pend_cell_next;
        pend_scr_reg  <= pend_scr_next;
        m_tdata_reg   <= m_tdata_next;
    end

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_cells (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

[src/tcw_checker.sv]
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the text console writer result stream.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tcw_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam logic [tcw_pkg::CURSOR_W-1:0] SCROLL_POS =
        tcw_pkg::CURSOR_W'((ROWS - 1) * COLUMNS);

    // a stalled beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // no beat right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat during reset");

    // a scroll leaves the cursor at column 0 of the bottom row, no cell data
    a_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[27] |-> m_tdata[26:16] == SCROLL_POS && m_tdata[15:0] == '0)
        else $error("scrolled beat with wrong cursor or cell");

    // cursor stays on the grid (checked only when the grid fits 2048 positions)
    a_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (CELLS > 2048) || (32'(m_tdata[26:16]) < 32'(CELLS)))
        else $error("cursor position beyond the grid");

endmodule

bind text_console_writer_unit tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[dv/text_console_writer_unit_tb.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit_tb
// Self-checking bench for the text console writer. A queue-fed driver sends
// put, clear, read and unused-kind requests; a scoreboard model of the cell
// grid, cursor and scroll pointer predicts each result beat, and the monitor
// compares every returned beat field by field. The attribute register is
// rewritten between drained phases; both stream sides stall at random.
// ----------------------------------------------------------------------------
module text_console_writer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = ROWS * COLUMNS;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 140;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 100;

    // request kind with no function in the block
    localparam logic [tcw_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef logic [tcw_pkg::RROW_W-1:0] row_t;

    typedef struct packed {
        logic [tcw_pkg::REQ_W-1:0]  req;
        logic [tcw_pkg::CHAR_W-1:0] code;
        logic [tcw_pkg::RROW_W-1:0] row;
        logic [tcw_pkg::RCOL_W-1:0] col;
    } console_request_t;

    typedef struct packed {
        tcw_pkg::cell_t   cell_value;
        tcw_pkg::cursor_t cursor_pos;
        logic             scrolled;
    } console_result_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [tcw_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [tcw_pkg::S_TUSER_W-1:0] s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [tcw_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tcw_pkg::ATTR_W-1:0]    cfg_data  = '0;

    console_request_t pending_requests[$];
    console_result_t  expected_results[$];
    int               outstanding   = 0;
    int               queued_items  = 0;
    int               error_count   = 0;
    int               idle_cycles   = 0;
    bit               calm          = 1'b0;

    // scoreboard copy of the console state
    tcw_pkg::cell_t             screen_model [CELLS];
    logic [tcw_pkg::RROW_W-1:0] cur_row;
    logic [tcw_pkg::RCOL_W-1:0] cur_col;
    logic [tcw_pkg::RROW_W-1:0] top_row;
    logic [tcw_pkg::ATTR_W-1:0] attr_model;

    text_console_writer_unit #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int cell_addr(input int row, input int col);
        return ((int'(top_row) + row) % ROWS) * COLUMNS + (col % COLUMNS);
    endfunction

    task automatic advance_line(output logic scroll);
        int c;
        cur_col = '0;
        if (int'(cur_row) + 1 < ROWS) begin
            cur_row = cur_row + 1'b1;
            scroll  = 1'b0;
        end else begin
            // scrolling only moves the top pointer; the new bottom row is blanked
            top_row = row_t'((int'(top_row) + 1) % ROWS);
            cur_row = row_t'(ROWS - 1);
            for (c = 0; c < COLUMNS; c++) begin
                screen_model[cell_addr(ROWS - 1, c)] = {attr_model, tcw_pkg::CODE_BLANK};
            end
            scroll = 1'b1;
        end
    endtask

    task automatic predict_request(input logic [tcw_pkg::REQ_W-1:0]  req,
                                   input logic [tcw_pkg::CHAR_W-1:0] code,
                                   input logic [tcw_pkg::RROW_W-1:0] rrow,
                                   input logic [tcw_pkg::RCOL_W-1:0] rcol);
        console_result_t res;
        logic            scroll;
        int              i;
        res    = '0;
        scroll = 1'b0;
        case (req)
            tcw_pkg::REQ_PUT: begin
                if (code == tcw_pkg::CODE_NEWLINE) begin
                    advance_line(scroll);
                end else if (code == tcw_pkg::CODE_BACKSPACE) begin
                    if (cur_col != 0) begin
                        cur_col = cur_col - 1'b1;
                        screen_model[cell_addr(int'(cur_row), int'(cur_col))] =
                            {attr_model, tcw_pkg::CODE_BLANK};
                    end
                end else begin
                    screen_model[cell_addr(int'(cur_row), int'(cur_col))] = {attr_model, code};
                    cur_col = cur_col + 1'b1;
                    if (int'(cur_col) >= COLUMNS) begin
                        advance_line(scroll);
                    end
                end
            end
            tcw_pkg::REQ_CLEAR: begin
                for (i = 0; i < CELLS; i++) begin
                    screen_model[i] = {attr_model, tcw_pkg::CODE_BLANK};
                end
                cur_row = '0;
                cur_col = '0;
                top_row = '0;
            end
            tcw_pkg::REQ_READ: begin
                if (int'(rrow) < ROWS && int'(rcol) < COLUMNS) begin
                    res.cell_value = screen_model[cell_addr(int'(rrow), int'(rcol))];
                end
            end
            default: ;
        endcase
        res.cursor_pos = tcw_pkg::cursor_t'(int'(cur_row) * COLUMNS + int'(cur_col));
        res.scrolled   = scroll;
        expected_results.push_back(res);
    endtask

    task automatic queue_request(input logic [tcw_pkg::REQ_W-1:0]  req,
                                 input logic [tcw_pkg::CHAR_W-1:0] code,
                                 input logic [tcw_pkg::RROW_W-1:0] row,
                                 input logic [tcw_pkg::RCOL_W-1:0] col);
        console_request_t r;
        r.req  = req;
        r.code = code;
        r.row  = row;
        r.col  = col;
        pending_requests.push_back(r);
        outstanding++;
        queued_items++;
    endtask

    task automatic write_attribute(input logic [tcw_pkg::ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        attr_model = value;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_count++;
    endtask

    // request driver
    always @(posedge aclk) begin : request_driver
        console_request_t next_req;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_request(s_tuser, s_tdata[7:0], s_tdata[12:8], s_tdata[19:13]);
            end
            if (!s_tvalid || s_tready) begin
                if (pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
                    next_req = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0000, next_req.col, next_req.row, next_req.code};
                    s_tuser  <= next_req.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge aclk) begin : result_monitor
        console_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_tdata, '0);
                end else begin
                    want = expected_results.pop_front();
                    outstanding--;
                    if (m_tdata[15:0] !== want.cell_value)
                        report_mismatch("cell_value", 32'(m_tdata[15:0]),
                                        32'(want.cell_value));
                    if (m_tdata[26:16] !== want.cursor_pos)
                        report_mismatch("cursor_pos", 32'(m_tdata[26:16]),
                                        32'(want.cursor_pos));
                    if (m_tdata[27] !== want.scrolled)
                        report_mismatch("scrolled", 32'(m_tdata[27]), 32'(want.scrolled));
                end
            end
            m_tready <= calm || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("** text_console_writer_unit: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int                         i, n, kind, len, phase, phase_start;
        logic [tcw_pkg::CHAR_W-1:0] code;
        logic [tcw_pkg::ATTR_W-1:0] attr;

        attr_model = tcw_pkg::ATTR_RESET;
        for (i = 0; i < CELLS; i++) begin
            screen_model[i] = {tcw_pkg::ATTR_RESET, tcw_pkg::CODE_BLANK};
        end
        cur_row = '0;
        cur_col = '0;
        top_row = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: grid corners, out-of-grid reads, high codes, backspace at home
        queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
        queue_request(tcw_pkg::REQ_READ, 8'hFF, 5'd24, 7'd79);
        queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd25, 7'd0);
        queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd80);
        queue_request(tcw_pkg::REQ_READ, 8'hFF, 5'd31, 7'd127);
        queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CODE_BACKSPACE, 5'd0, 7'd0);
        queue_request(tcw_pkg::REQ_PUT, 8'hFF, 5'd31, 7'd127);
        queue_request(tcw_pkg::REQ_PUT, 8'h80, 5'd0, 7'd0);
        queue_request(tcw_pkg::REQ_PUT, 8'h00, 5'd0, 7'd0);
        queue_request(tcw_pkg::REQ_PUT, 8'h7F, 5'd0, 7'd0);
        for (i = 0; i < 4; i++) begin
            queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'(i));
        end
        queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CODE_BACKSPACE, 5'd0, 7'd0);
        queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd3);
        queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CODE_NEWLINE, 5'd0, 7'd0);
        queue_request(REQ_UNUSED, 8'hFF, 5'd31, 7'd127);
        queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd1, 7'd0);
        queue_request(tcw_pkg::REQ_CLEAR, 8'h00, 5'd0, 7'd0);
        queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
        queue_request(tcw_pkg::REQ_READ, 8'h00, 5'd0, 7'd1);

        for (phase = 0; phase < PHASES; phase++) begin
            // drain before touching the attribute register
            while (outstanding != 0) @(posedge aclk);
            calm = 1'b0;
            attr = (phase == 0) ? 8'hFF : (phase == 1) ? 8'h00 : 8'($urandom_range(0, 255));
            write_attribute(attr);
            calm = (phase == 2);

            phase_start = queued_items;
            while (queued_items - phase_start < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                if (kind < 60) begin
                    // a line of text; some run past the last column
                    len = ($urandom_range(0, 99) < 15) ? $urandom_range(70, 95)
                                                       : $urandom_range(0, 12);
                    for (i = 0; i < len; i++) begin
                        if ($urandom_range(0, 99) < 8)
                            code = tcw_pkg::CODE_BACKSPACE;
                        else if ($urandom_range(0, 99) < 85)
                            code = 8'($urandom_range(32, 126));
                        else
                            code = 8'($urandom_range(0, 255));
                        queue_request(tcw_pkg::REQ_PUT, code, 5'($urandom), 7'($urandom));
                    end
                    if ($urandom_range(0, 99) < 80)
                        queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CODE_NEWLINE,
                                      5'($urandom), 7'($urandom));
                end else if (kind < 85) begin
                    n = $urandom_range(1, 4);
                    for (i = 0; i < n; i++) begin
                        if ($urandom_range(0, 99) < 80)
                            queue_request(tcw_pkg::REQ_READ, 8'($urandom),
                                          5'($urandom_range(0, 24)),
                                          ($urandom_range(0, 1) != 0) ?
                                          7'($urandom_range(0, 15)) : 7'($urandom_range(0, 79)));
                        else
                            queue_request(tcw_pkg::REQ_READ, 8'($urandom), 5'($urandom),
                                          7'($urandom));
                    end
                end else if (kind < 92) begin
                    n = $urandom_range(1, 5);
                    for (i = 0; i < n; i++) begin
                        queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CODE_BACKSPACE,
                                      5'($urandom), 7'($urandom));
                    end
                end else if (kind < 97) begin
                    n = $urandom_range(1, 6);
                    for (i = 0; i < n; i++) begin
                        queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CODE_NEWLINE,
                                      5'($urandom), 7'($urandom));
                    end
                end else if (kind < 99) begin
                    queue_request(REQ_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
                end else begin
                    queue_request(tcw_pkg::REQ_CLEAR, 8'($urandom), 5'($urandom),
                                  7'($urandom));
                end
            end
        end

        while (outstanding != 0) @(posedge aclk);
        calm = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0)
            report_mismatch("expected beats never returned", '0,
                            32'(expected_results.size()));

        if (error_count == 0) begin
            $display("** text_console_writer_unit: PASSED **");
        end else begin
            $display("** text_console_writer_unit: FAILED **");
        end
        $finish;
    end

endmodule
